// ----- rtl/kts_pkg.sv -----
// Shared types and constants for the keyframe track sampler.
// Used by every module of the block; depends on nothing else.
package kts_pkg;

   localparam int FRAME_W    = 24;
   localparam int VALUE_W    = 32;
   localparam int T_W        = 17;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_W    = 7;
   localparam int INDEX_W    = 6;
   localparam int DT_W       = 16;

   localparam logic [FRAME_W-1:0] FRAME_MAX = 24'hFFFFFF;
   localparam logic [T_W-1:0]     T_ONE     = 17'h10000;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_ADVANCE = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_SAMPLE  = 2'd3;

   localparam logic [1:0] REG_START_FRAME = 2'd0;
   localparam logic [1:0] REG_END_FRAME   = 2'd1;
   localparam logic [1:0] REG_POS_COUNT   = 2'd2;
   localparam logic [1:0] REG_SCALE_COUNT = 2'd3;

   typedef enum logic [2:0] {
      KIND_LOAD,
      KIND_ADVANCE,
      KIND_RESTART,
      KIND_SAMPLE,
      KIND_SKIP
   } kind_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic               table_select;
      logic [INDEX_W-1:0] key_index;
      logic [FRAME_W-1:0] key_frame;
      logic signed [VALUE_W-1:0] value_x;
      logic signed [VALUE_W-1:0] value_y;
      logic signed [VALUE_W-1:0] value_z;
      logic [DT_W-1:0]    delta_time;
   } req_type;

   typedef struct packed {
      logic               valid_res;
      logic signed [VALUE_W-1:0] out_x;
      logic signed [VALUE_W-1:0] out_y;
      logic signed [VALUE_W-1:0] out_z;
      logic [FRAME_W-1:0] frame_now;
   } rsp_type;

   typedef struct packed {
      kind_type           kind;
      logic               table_select;
      logic [INDEX_W-1:0] key_index;
      logic [FRAME_W-1:0] frame;
      logic [VALUE_W-1:0] value_x;
      logic [VALUE_W-1:0] value_y;
      logic [VALUE_W-1:0] value_z;
   } cmd_type;

   typedef struct packed {
      logic [FRAME_W-1:0] start_frame;
      logic [FRAME_W-1:0] end_frame;
      logic [COUNT_W-1:0] position_key_count;
      logic [COUNT_W-1:0] scale_key_count;
   } cfg_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [VALUE_W-1:0] value_x;
      logic [VALUE_W-1:0] value_y;
      logic [VALUE_W-1:0] value_z;
   } key_type;

endpackage

// ----- rtl/kts_cmd_queue.sv -----
// Two-entry command queue between the front and back parts.
// Depends on kts_pkg for the command type.
module kts_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  kts_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output kts_pkg::cmd_type pop_data
);

   kts_pkg::cmd_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/kts_front.sv -----
// Front part: configuration registers and classification of request words.
// Depends on kts_pkg; feeds kts_cmd_queue.
module kts_front #(
   parameter int KEY_DEPTH  = 64,
   parameter int FRAME_RATE = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [kts_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [kts_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [kts_pkg::CSR_DATA_W-1:0]      prdata,
   output kts_pkg::cfg_type                    cfg,
   input  kts_pkg::req_type                    req_data,
   output kts_pkg::cmd_type                    cmd
);

   localparam int RATE_W   = $clog2(FRAME_RATE + 1);
   localparam int SCALED_W = kts_pkg::DT_W + RATE_W;

   kts_pkg::cfg_type cfg_ff, cfg_in;
   logic [SCALED_W-1:0] scaled;
   logic [1:0]          reg_sel;

   assign reg_sel = paddr[3:2];
   assign cfg     = cfg_ff;
   assign scaled  = SCALED_W'(req_data.delta_time) * SCALED_W'(FRAME_RATE);

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_sel)
            kts_pkg::REG_START_FRAME: cfg_in.start_frame = pwdata[kts_pkg::FRAME_W-1:0];
            kts_pkg::REG_END_FRAME:   cfg_in.end_frame = pwdata[kts_pkg::FRAME_W-1:0];
            kts_pkg::REG_POS_COUNT:
               cfg_in.position_key_count = pwdata[kts_pkg::COUNT_W-1:0];
            kts_pkg::REG_SCALE_COUNT:
               cfg_in.scale_key_count = pwdata[kts_pkg::COUNT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         kts_pkg::REG_START_FRAME: prdata = 32'(cfg_ff.start_frame);
         kts_pkg::REG_END_FRAME:   prdata = 32'(cfg_ff.end_frame);
         kts_pkg::REG_POS_COUNT:   prdata = 32'(cfg_ff.position_key_count);
         kts_pkg::REG_SCALE_COUNT: prdata = 32'(cfg_ff.scale_key_count);
         default:                  prdata = '0;
      endcase
   end

   always_comb begin
      cmd.table_select = req_data.table_select;
      cmd.key_index    = req_data.key_index;
      cmd.value_x      = req_data.value_x;
      cmd.value_y      = req_data.value_y;
      cmd.value_z      = req_data.value_z;
      cmd.frame        = '0;
      unique case (req_data.operation)
         kts_pkg::OP_LOAD: begin
            cmd.frame = req_data.key_frame;
            cmd.kind  = (32'(req_data.key_index) < KEY_DEPTH) ?
                        kts_pkg::KIND_LOAD : kts_pkg::KIND_SKIP;
         end
         kts_pkg::OP_ADVANCE: begin
            cmd.frame = kts_pkg::FRAME_W'(scaled >> 8);
            cmd.kind  = kts_pkg::KIND_ADVANCE;
         end
         kts_pkg::OP_RESTART: cmd.kind = kts_pkg::KIND_RESTART;
         default:             cmd.kind = kts_pkg::KIND_SAMPLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/kts_div.sv -----
// Restoring divider, one quotient bit a cycle, for the interpolation weight.
// Depends on kts_pkg; used by kts_back.
module kts_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kts_pkg::FRAME_W-1:0]   numer,
   input  logic [kts_pkg::FRAME_W-1:0]   denom,
   output logic                          done,
   output logic [kts_pkg::T_W-1:0]       quotient
);

   localparam int FW = kts_pkg::FRAME_W;
   localparam int TW = kts_pkg::T_W;

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [FW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [TW-1:0] sh_ff, sh_in, q_ff, q_in;
   logic [FW:0]   trial;

   assign done     = done_ff;
   assign quotient = q_ff;
   assign trial    = {rem_ff, sh_ff[TW-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, numer[FW-1:1]};
         sh_in   = {numer[0], 16'h0000};
         den_in  = denom;
         q_in    = '0;
      end else if (busy_ff) begin
         sh_in = {sh_ff[TW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = FW'(trial - {1'b0, den_ff});
            q_in   = {q_ff[TW-2:0], 1'b1};
         end else begin
            rem_in = trial[FW-1:0];
            q_in   = {q_ff[TW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(TW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
   end

endmodule

// ----- rtl/kts_back.sv -----
// Back part: key memory, frame counter, bracket search and interpolation.
// Depends on kts_pkg and kts_div; takes commands from kts_cmd_queue.
module kts_back #(
   parameter int KEY_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  kts_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  kts_pkg::cmd_type cmd,
   output logic             res_valid,
   input  logic             res_ready,
   output kts_pkg::rsp_type res_data
);

   localparam int IW = $clog2(KEY_DEPTH);
   localparam int NW = IW + 1;
   localparam int AW = IW + 1;
   localparam int SW = IW + 2;
   localparam int FW = kts_pkg::FRAME_W;
   localparam int VW = kts_pkg::VALUE_W;
   localparam int TW = kts_pkg::T_W;
   localparam int COUNT_SEL = kts_pkg::COUNT_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ADV_SUM, ST_ADV_CMP, ST_ADV_ADD, ST_ADV_SAT,
      ST_EDGE_RD, ST_EDGE, ST_SRCH_RD, ST_SRCH_CHK, ST_VAL_RD, ST_VAL,
      ST_DIV, ST_MUL, ST_ACC, ST_DONE
   } state_type;

   state_type            state_ff;
   kts_pkg::cmd_type     ent_ff;
   kts_pkg::rsp_type     res_ff;
   logic [FW-1:0]        cur_ff;
   logic [FW+1:0]        sum_ff;
   logic [NW-1:0]        n_ff;
   logic [IW-1:0]        last_ff, l_ff, r_ff, m_ff, m2_ff, i1_ff, i2_ff;
   logic [SW-1:0]        steps_ff;
   logic [TW-1:0]        t_ff;
   logic signed [VW:0]   diff_ff [3];
   logic [VW-1:0]        base_ff [3];
   logic [1:0]           comp_ff;
   logic signed [VW+TW:0] prod_ff;

   kts_pkg::key_type     mem [2*KEY_DEPTH];
   kts_pkg::key_type     rd_a_ff, rd_b_ff;
   logic                 rd_en, mem_we;
   logic [IW-1:0]        ra, rb;
   logic [NW-1:0]        n_sel, lr_sum, m_inc;
   logic [COUNT_SEL-1:0] cnt_sel;
   logic [IW-1:0]        m_calc, m2_calc;
   logic                 div_start, div_done, div_go;
   logic [TW-1:0]        div_q;
   logic [VW-1:0]        acc;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign mem_we    = (state_ff == ST_IDLE) && cmd_valid && (cmd.kind == kts_pkg::KIND_LOAD);
   assign rd_en     = (state_ff == ST_EDGE_RD) || (state_ff == ST_SRCH_RD)
                      || (state_ff == ST_VAL_RD);
   assign div_go    = (rd_b_ff.frame > rd_a_ff.frame) && (cur_ff >= rd_a_ff.frame);
   assign div_start = (state_ff == ST_VAL) && (i1_ff != i2_ff) && div_go;

   assign cnt_sel = cmd.table_select ? cfg.scale_key_count : cfg.position_key_count;
   assign n_sel   = (32'(cnt_sel) > KEY_DEPTH) ? NW'(KEY_DEPTH) : NW'(cnt_sel);
   assign lr_sum  = {1'b0, l_ff} + {1'b0, r_ff};
   assign m_calc  = lr_sum[NW-1:1];
   assign m_inc   = {1'b0, m_calc} + NW'(1);
   assign m2_calc = (m_inc < n_ff) ? m_inc[IW-1:0] : m_calc;
   assign acc     = base_ff[comp_ff] + VW'(prod_ff >>> 16);

   always_comb begin
      res_data           = res_ff;
      res_data.frame_now = cur_ff;
   end

   always_comb begin
      case (state_ff)
         ST_EDGE_RD: begin
            ra = last_ff;
            rb = '0;
         end
         ST_SRCH_RD: begin
            ra = m_calc;
            rb = m2_calc;
         end
         default: begin
            ra = i1_ff;
            rb = i2_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[{cmd.table_select, IW'(cmd.key_index)}] <=
            '{frame: cmd.frame, value_x: cmd.value_x, value_y: cmd.value_y,
              value_z: cmd.value_z};
      end
      if (rd_en) begin
         rd_a_ff <= mem[AW'({ent_ff.table_select, ra})];
         rd_b_ff <= mem[AW'({ent_ff.table_select, rb})];
      end
   end

   kts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (cur_ff - rd_a_ff.frame),
      .denom    (rd_b_ff.frame - rd_a_ff.frame),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  ent_ff <= cmd;
                  res_ff <= '0;
                  n_ff   <= n_sel;
                  last_ff <= IW'(n_sel - NW'(1));
                  unique case (cmd.kind)
                     kts_pkg::KIND_ADVANCE: state_ff <= ST_ADV_SUM;
                     kts_pkg::KIND_RESTART: begin
                        cur_ff   <= cfg.start_frame;
                        state_ff <= ST_DONE;
                     end
                     kts_pkg::KIND_SAMPLE: begin
                        if (n_sel == '0) begin
                           state_ff <= ST_DONE;
                        end else if (n_sel == NW'(1)) begin
                           i1_ff    <= '0;
                           i2_ff    <= '0;
                           state_ff <= ST_VAL_RD;
                        end else begin
                           state_ff <= ST_EDGE_RD;
                        end
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_ADV_SUM: begin
               sum_ff   <= (FW+2)'(cur_ff) + (FW+2)'(ent_ff.frame);
               state_ff <= ST_ADV_CMP;
            end
            ST_ADV_CMP: begin
               if (sum_ff > (FW+2)'(cfg.end_frame)) begin
                  sum_ff   <= sum_ff - (FW+2)'(cfg.end_frame);
                  state_ff <= ST_ADV_ADD;
               end else begin
                  state_ff <= ST_ADV_SAT;
               end
            end
            ST_ADV_ADD: begin
               sum_ff   <= sum_ff + (FW+2)'(cfg.start_frame);
               state_ff <= ST_ADV_SAT;
            end
            ST_ADV_SAT: begin
               cur_ff   <= (sum_ff > (FW+2)'(kts_pkg::FRAME_MAX)) ?
                           kts_pkg::FRAME_MAX : sum_ff[FW-1:0];
               state_ff <= ST_DONE;
            end
            ST_EDGE_RD: state_ff <= ST_EDGE;
            ST_EDGE: begin
               if (cur_ff > rd_a_ff.frame) begin
                  i1_ff    <= last_ff;
                  i2_ff    <= last_ff;
                  state_ff <= ST_VAL_RD;
               end else if (cur_ff < rd_b_ff.frame) begin
                  i1_ff    <= '0;
                  i2_ff    <= '0;
                  state_ff <= ST_VAL_RD;
               end else begin
                  l_ff     <= '0;
                  r_ff     <= last_ff;
                  steps_ff <= '0;
                  state_ff <= ST_SRCH_RD;
               end
            end
            ST_SRCH_RD: begin
               m_ff     <= m_calc;
               m2_ff    <= m2_calc;
               steps_ff <= steps_ff + SW'(1);
               state_ff <= ST_SRCH_CHK;
            end
            ST_SRCH_CHK: begin
               if ((rd_a_ff.frame <= cur_ff) && (rd_b_ff.frame >= cur_ff)) begin
                  i1_ff    <= m_ff;
                  i2_ff    <= m2_ff;
                  state_ff <= ST_VAL_RD;
               end else begin
                  if (rd_a_ff.frame > cur_ff) begin
                     r_ff <= m_ff;
                  end else begin
                     l_ff <= m_ff;
                  end
                  if (steps_ff == SW'(2 * KEY_DEPTH)) begin
                     i1_ff    <= last_ff;
                     i2_ff    <= last_ff;
                     state_ff <= ST_VAL_RD;
                  end else begin
                     state_ff <= ST_SRCH_RD;
                  end
               end
            end
            ST_VAL_RD: state_ff <= ST_VAL;
            ST_VAL: begin
               res_ff.valid_res <= 1'b1;
               if (i1_ff == i2_ff) begin
                  res_ff.out_x <= rd_a_ff.value_x;
                  res_ff.out_y <= rd_a_ff.value_y;
                  res_ff.out_z <= rd_a_ff.value_z;
                  state_ff     <= ST_DONE;
               end else begin
                  diff_ff[0] <= $signed({rd_b_ff.value_x[VW-1], rd_b_ff.value_x})
                              - $signed({rd_a_ff.value_x[VW-1], rd_a_ff.value_x});
                  diff_ff[1] <= $signed({rd_b_ff.value_y[VW-1], rd_b_ff.value_y})
                              - $signed({rd_a_ff.value_y[VW-1], rd_a_ff.value_y});
                  diff_ff[2] <= $signed({rd_b_ff.value_z[VW-1], rd_b_ff.value_z})
                              - $signed({rd_a_ff.value_z[VW-1], rd_a_ff.value_z});
                  base_ff[0] <= rd_a_ff.value_x;
                  base_ff[1] <= rd_a_ff.value_y;
                  base_ff[2] <= rd_a_ff.value_z;
                  comp_ff    <= '0;
                  t_ff       <= '0;
                  state_ff   <= div_go ? ST_DIV : ST_MUL;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  t_ff     <= (div_q > kts_pkg::T_ONE) ? kts_pkg::T_ONE : div_q;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= diff_ff[comp_ff] * $signed({1'b0, t_ff});
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               case (comp_ff)
                  2'd0:    res_ff.out_x <= acc;
                  2'd1:    res_ff.out_y <= acc;
                  default: res_ff.out_z <= acc;
               endcase
               if (comp_ff == 2'd2) begin
                  state_ff <= ST_DONE;
               end else begin
                  comp_ff  <= comp_ff + 2'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_DONE: begin
               if (res_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/keyframe_track_sampler.sv -----
// Top level of the keyframe track sampler: front, queue, back, output register.
// Depends on kts_pkg, kts_front, kts_cmd_queue and kts_back.
//
// Request words (req_*) carry one operation each: load a key, advance the
// current frame, restart at the start frame, or sample a table. Every request
// word yields exactly one response word (rsp_*), in order, holding the
// sampled value where there is one and the current frame after the operation.
// Registers are to be written through the APB-style port only while the block
// is idle; the block itself does not enforce this. A front stage classifies
// request words into a two-entry queue; a back engine executes them one at a
// time. An advance adds, checks against the end frame, wraps back towards the
// start frame and saturates. A sample runs a bracket search whose steps number
// about log2 of the key count for a sorted table; each step reads two keys at
// once from the key memory, then the divider gives the weight for the shared
// multiplier, used three times. The response register lets the back engine
// finish a word while the previous response waits; a stalled receiver then
// holds the engine, and the queue keeps accepting until it is full. Reset
// clears the registers, the current frame and all handshake state; the key
// memory is not cleared and must be loaded before it is sampled.
module keyframe_track_sampler #(
   parameter int KEY_DEPTH  = 64,
   parameter int FRAME_RATE = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  kts_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output kts_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [kts_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [kts_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [kts_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   kts_pkg::cfg_type cfg;
   kts_pkg::cmd_type cmd_in, cmd_out;
   kts_pkg::rsp_type res_data, rsp_data_ff;
   logic             cmd_valid, cmd_ready, res_valid, res_ready;
   logic             rsp_valid_ff, rsp_valid_in;

   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign res_ready = !rsp_valid_ff || rsp_ready;

   kts_front #(
      .KEY_DEPTH  (KEY_DEPTH),
      .FRAME_RATE (FRAME_RATE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .cfg      (cfg),
      .req_data (req_data),
      .cmd      (cmd_in)
   );

   kts_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (cmd_in),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_data   (cmd_out)
   );

   kts_back #(
      .KEY_DEPTH (KEY_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd_out),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response word valid straight after reset");

   a_invalid_rsp_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.valid_res) |->
      (rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0))
      else $error("response word without a sample carries a non-zero value");

endmodule

// ----- dv/tb_keyframe_track_sampler.sv -----
// Self-checking testbench for the keyframe track sampler: directed table, then random words.
// Depends on kts_pkg and the RTL top level keyframe_track_sampler.
`timescale 1ns / 1ps
module tb_keyframe_track_sampler;

   localparam int KEYS = 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE = 200;
   localparam int FW = kts_pkg::FRAME_W;
   localparam int VW = kts_pkg::VALUE_W;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   kts_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   kts_pkg::rsp_type rsp_data;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [kts_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [kts_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [kts_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   keyframe_track_sampler uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow state of the block.
   logic [FW-1:0] sh_start, sh_end, sh_frame;
   logic [kts_pkg::COUNT_W-1:0] sh_count[2];
   logic [FW-1:0] sh_time[2][KEYS];
   logic [VW-1:0] sh_x[2][KEYS], sh_y[2][KEYS], sh_z[2][KEYS];
   bit sh_written[2][KEYS];

   kts_pkg::rsp_type expected_words[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit timed_out = 1'b0;

   function automatic logic [VW-1:0] blend(logic [VW-1:0] a, logic [VW-1:0] b,
                                            longint unsigned t);
      longint sa, d, p, q;
      sa = longint'($signed(a));
      d = longint'($signed(b)) - sa;
      p = d * longint'(t);
      if (p >= 0) q = p >>> 16;
      else q = -((-p + 65535) >>> 16);
      return VW'(sa + q);
   endfunction

   function automatic kts_pkg::rsp_type predict_word(kts_pkg::req_type w);
      kts_pkg::rsp_type r;
      int tb, n, last, lo, hi, mid, mid2, steps, i1, i2;
      longint unsigned sum, t;
      logic [FW-1:0] f, f1, f2;
      r = '0;
      tb = w.table_select;
      case (w.operation)
         kts_pkg::OP_LOAD: begin
            sh_time[tb][w.key_index] = w.key_frame;
            sh_x[tb][w.key_index] = w.value_x;
            sh_y[tb][w.key_index] = w.value_y;
            sh_z[tb][w.key_index] = w.value_z;
            sh_written[tb][w.key_index] = 1'b1;
         end
         kts_pkg::OP_ADVANCE: begin
            sum = longint'(sh_frame) + ((longint'(w.delta_time) * 24) >> 8);
            if (sum > sh_end) sum = longint'(sh_start) + (sum - sh_end);
            sh_frame = (sum > kts_pkg::FRAME_MAX) ? kts_pkg::FRAME_MAX : FW'(sum);
         end
         kts_pkg::OP_RESTART: sh_frame = sh_start;
         default: begin
            n = sh_count[tb];
            if (n > KEYS) n = KEYS;
            if (n > 0) begin
               f = sh_frame;
               last = n - 1;
               i1 = last;
               i2 = last;
               if (n != 1 && f <= sh_time[tb][last]) begin
                  if (f < sh_time[tb][0]) begin
                     i1 = 0;
                     i2 = 0;
                  end else begin
                     lo = 0;
                     hi = last;
                     steps = 0;
                     while (hi >= lo && steps < 2 * KEYS) begin
                        mid = (lo + hi) / 2;
                        mid2 = (mid + 1 < n) ? mid + 1 : mid;
                        steps++;
                        if (sh_time[tb][mid] <= f && sh_time[tb][mid2] >= f) begin
                           i1 = mid;
                           i2 = mid2;
                           break;
                        end
                        if (sh_time[tb][mid] > f) hi = mid;
                        else lo = mid;
                     end
                  end
               end
               r.valid_res = 1'b1;
               if (i1 == i2) begin
                  r.out_x = sh_x[tb][i1];
                  r.out_y = sh_y[tb][i1];
                  r.out_z = sh_z[tb][i1];
               end else begin
                  f1 = sh_time[tb][i1];
                  f2 = sh_time[tb][i2];
                  t = 0;
                  if (f2 > f1 && f >= f1) begin
                     t = (longint'(f - f1) << 16) / longint'(f2 - f1);
                     if (t > 65536) t = 65536;
                  end
                  r.out_x = blend(sh_x[tb][i1], sh_x[tb][i2], t);
                  r.out_y = blend(sh_y[tb][i1], sh_y[tb][i2], t);
                  r.out_z = blend(sh_z[tb][i1], sh_z[tb][i2], t);
               end
            end
         end
      endcase
      r.frame_now = sh_frame;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response word %p", rsp_data);
         end else begin
            if (rsp_data !== expected_words[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Response word wrong: expected %p, got %p",
                           expected_words[0], rsp_data);
            end
            void'(expected_words.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: random stall per word, with stall-free stretches.
   bit rsp_fast = 1'b0;
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = rsp_fast ? 0 : $urandom_range(0, 14);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic write_reg(logic [1:0] which, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= kts_pkg::CSR_ADDR_W'({which, 2'b00});
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (which)
         kts_pkg::REG_START_FRAME: sh_start = value[FW-1:0];
         kts_pkg::REG_END_FRAME:   sh_end = value[FW-1:0];
         kts_pkg::REG_POS_COUNT:   sh_count[0] = value[kts_pkg::COUNT_W-1:0];
         default:                  sh_count[1] = value[kts_pkg::COUNT_W-1:0];
      endcase
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   bit send_fast = 1'b0;
   task automatic send_word(kts_pkg::req_type w, bit pinned, kts_pkg::rsp_type pinned_word);
      kts_pkg::rsp_type p;
      int gap;
      gap = send_fast ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      p = predict_word(w);
      if (pinned && p !== pinned_word) begin
         mismatches++;
         if (mismatches <= 10) $display("Table row disagrees: %p vs %p", pinned_word, p);
      end
      expected_words.push_back(p);
      req_data <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic kts_pkg::req_type make_word(logic [1:0] op, bit tb, int idx,
                                                  logic [23:0] fr, logic [31:0] x,
                                                  logic [31:0] y, logic [31:0] z,
                                                  logic [15:0] dt);
      kts_pkg::req_type w;
      w.operation = op;
      w.table_select = tb;
      w.key_index = kts_pkg::INDEX_W'(idx);
      w.key_frame = fr;
      w.value_x = x;
      w.value_y = y;
      w.value_z = z;
      w.delta_time = dt;
      return w;
   endfunction

   function automatic kts_pkg::rsp_type make_rsp(bit v, logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z, logic [23:0] fr);
      kts_pkg::rsp_type r;
      r.valid_res = v;
      r.out_x = x;
      r.out_y = y;
      r.out_z = z;
      r.frame_now = fr;
      return r;
   endfunction

   typedef struct {
      kts_pkg::req_type w;
      bit pinned;
      kts_pkg::rsp_type r;
   } row_type;

   // Loads a sorted table of n keys with random content.
   task automatic load_table(bit tb, int n, int spread);
      logic [23:0] fr;
      fr = 24'($urandom_range(0, 4000));
      for (int i = 0; i < n; i++) begin
         send_word(make_word(kts_pkg::OP_LOAD, tb, i, fr, $urandom, $urandom, $urandom,
                             16'($urandom)), 0, '0);
         fr = fr + 24'($urandom_range(0, spread));
      end
   endtask

   initial begin
      row_type rows[$];
      int n;
      logic [1:0] op;
      bit tb;
      sh_start = '0;
      sh_end = '0;
      sh_frame = '0;
      sh_count[0] = '0;
      sh_count[1] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rows.push_back('{make_word(kts_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 1,
                       make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_word(kts_pkg::OP_SAMPLE, 1, 63, '1, '1, '1, '1, '1), 1,
                       make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_word(kts_pkg::OP_LOAD, 0, 0, 24'h000100, 32'h7FFFFFFF,
                                 32'h80000000, 32'h00010000, 0), 1,
                       make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_word(kts_pkg::OP_LOAD, 0, 1, 24'h000300, 32'h80000000,
                                 32'h7FFFFFFF, 32'hFFFF0000, 16'hFFFF), 1,
                       make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_word(kts_pkg::OP_LOAD, 0, 2, 24'h000300, 0, 0, 0, 0), 1,
                       make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_word(kts_pkg::OP_LOAD, 0, 63, 24'hFFFFFF, '1, '1, '1, 0), 1,
                       make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_word(kts_pkg::OP_LOAD, 1, 0, 0, 32'h00050000, 32'h00060000,
                                 32'h00070000, 0), 1, make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_word(kts_pkg::OP_LOAD, 1, 63, 24'h7FFFFF, 1, 2, 3, 0), 1,
                       make_rsp(0, 0, 0, 0, 0)});
      foreach (rows[i]) send_word(rows[i].w, rows[i].pinned, rows[i].r);
      rows.delete();
      drain();
      write_reg(kts_pkg::REG_POS_COUNT, 3);
      write_reg(kts_pkg::REG_SCALE_COUNT, 1);
      write_reg(kts_pkg::REG_START_FRAME, 24'h000080);
      write_reg(kts_pkg::REG_END_FRAME, 24'h000400);
      rows.push_back('{make_word(kts_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 1,
                       make_rsp(1, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 0)});
      rows.push_back('{make_word(kts_pkg::OP_SAMPLE, 1, 0, 0, 0, 0, 0, 0), 1,
                       make_rsp(1, 32'h00050000, 32'h00060000, 32'h00070000, 0)});
      rows.push_back('{make_word(kts_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0, 16'h1000), 0, '0});
      rows.push_back('{make_word(kts_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_word(kts_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0, 16'h0AAA), 0, '0});
      rows.push_back('{make_word(kts_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_word(kts_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, '0});
      rows.push_back('{make_word(kts_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_word(kts_pkg::OP_RESTART, 1, 5, 0, 0, 0, 0, 0), 1,
                       make_rsp(0, 0, 0, 0, 24'h000080)});
      rows.push_back('{make_word(kts_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0, 16'h0000), 1,
                       make_rsp(0, 0, 0, 0, 24'h000080)});
      foreach (rows[i]) send_word(rows[i].w, rows[i].pinned, rows[i].r);
      drain();
      // Saturation of the frame at the top of its range.
      write_reg(kts_pkg::REG_END_FRAME, 24'hFFFFFF);
      write_reg(kts_pkg::REG_START_FRAME, 24'hFFFF00);
      send_word(make_word(kts_pkg::OP_RESTART, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      send_word(make_word(kts_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, '0);
      send_word(make_word(kts_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         send_fast = (phase == 3);
         rsp_fast = (phase == 3) || (phase == 6);
         tb = phase[0];
         n = (phase == 5) ? 64 : $urandom_range(1, 12);
         load_table(tb, n, (phase == 4) ? 0 : $urandom_range(1, 2000));
         load_table(!tb, $urandom_range(1, 8), 500);
         drain();
         write_reg(tb ? kts_pkg::REG_SCALE_COUNT : kts_pkg::REG_POS_COUNT,
                   (phase == 7) ? 7'd127 : (phase == 2) ? 7'd0 : kts_pkg::COUNT_W'(n));
         write_reg(kts_pkg::REG_START_FRAME, (phase == 6) ? 24'h0 : $urandom_range(0, 3000));
         write_reg(kts_pkg::REG_END_FRAME, (phase == 1) ? 24'h0 : $urandom_range(3000, 40000));
         for (int k = 0; k < 80; k++) begin
            op = $urandom_range(0, 9) < 5 ? kts_pkg::OP_SAMPLE : 2'($urandom_range(0, 3));
            if (op == kts_pkg::OP_LOAD) begin
               n = sh_count[tb] > KEYS ? KEYS : sh_count[tb];
               // Rewrites keep tables partly unsorted; indexes past the loaded run
               // are still written so nothing unread is sampled.
               send_word(make_word(op, 1'($urandom_range(0, 1)), $urandom_range(0, 63),
                                   24'($urandom), $urandom, $urandom, $urandom,
                                   16'($urandom)), 0, '0);
            end else begin
               send_word(make_word(op, (k % 5 == 0) ? !tb : tb, $urandom, 24'($urandom),
                                   $urandom, $urandom, $urandom, 16'($urandom)), 0, '0);
            end
            if (k == 40) drain();
         end
         drain();
         // Counts past the loaded run would read unwritten entries; keep only valid ones.
         for (int s = 0; s < 2; s++) begin
            n = 0;
            while (n < KEYS && sh_written[s][n]) n++;
            if (sh_count[s] > n)
               write_reg(s ? kts_pkg::REG_SCALE_COUNT : kts_pkg::REG_POS_COUNT,
                         kts_pkg::COUNT_W'(n));
         end
      end
      drain();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
